// ===== src/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SEQ_SPACE    = 16;
	localparam int SEQ_W        = 4;
	localparam int HANDLE_W     = 32;
	localparam int LEN_W        = 8;
	localparam int WIN_W        = 4;
	localparam int MAX_WINDOW   = 8;
	localparam int RING_IDX_W   = 3;
	localparam int WIN_CAP      = (MAX_WINDOW < SEQ_SPACE / 2) ? MAX_WINDOW : SEQ_SPACE / 2;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [SEQ_W-1:0] seq;
	} ack_rec_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	// zero acts as one, anything above the cap saturates
	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
		logic [WIN_W-1:0] w;
		w = ws;
		if (w == '0)
			w = WIN_W'(1);
		if (w > WIN_W'(WIN_CAP))
			w = WIN_W'(WIN_CAP);
		return w;
	endfunction

endpackage

// ===== src/selective_repeat_receiver.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective repeat ARQ receiver on packet descriptors: delivers in-order
// packets and drains buffered successors, stores out-of-order ones, acks and
// re-acks from a ring of recently acked numbers.
// ----------------------------------------------------------------------------
// The first result is registered and appears in the cycle after the transaction is taken.
// Stored, corrupt and out-of-window packets leave busy low.
// An in-order packet with k buffered successors holds busy while they drain,
// one slot RAM read per drained packet, k up to the window, and while its ack goes out.
// Reset clears the window register to 4, the lower edge, all slot and ring
// valid flops at once; no clearing pass. Results cannot be stalled.
module selective_repeat_receiver import srr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [SEQ_W-1:0]    seq_num,
	input  logic                checksum_ok,
	input  logic [HANDLE_W-1:0] payload_handle,
	input  logic [LEN_W-1:0]    payload_length,
	input  logic                cfg_wr_en,
	input  logic [WIN_W-1:0]    cfg_wr_data,
	output logic                result_valid,
	output logic                result_kind,
	output logic [SEQ_W-1:0]    out_seq,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [LEN_W-1:0]    out_length,
	output logic                last_of_run
);

	state_t               state_q, state_d;
	logic [WIN_W-1:0]     window_size_q;
	logic [WIN_W-1:0]     win;
	logic [SEQ_W-1:0]     le_q, le_d;
	logic [WIN_W-1:0]     cnt_q, cnt_d;
	logic [SEQ_W-1:0]     seq_q, seq_d;
	logic [SEQ_SPACE-1:0] slot_valid_q, slot_valid_d;

	logic                 res_valid_q, res_valid_d;
	logic                 res_kind_q, res_kind_d;
	logic [SEQ_W-1:0]     res_seq_q, res_seq_d;
	logic [HANDLE_W-1:0]  res_handle_q, res_handle_d;
	logic [LEN_W-1:0]     res_len_q, res_len_d;
	logic                 res_last_q, res_last_d;

	logic [SEQ_W-1:0]     seq_off;
	logic                 in_win;
	logic                 ring_hit;
	ack_rec_t             ack_rec;
	logic                 ram_we;
	slot_t                ram_wdata;
	slot_t                ram_rdata;

	assign win     = eff_window(window_size_q);
	assign seq_off = seq_num - le_q;  // sequence space is a power of two
	assign in_win  = WIN_W'(seq_off) < win;

	assign ram_wdata.handle = payload_handle;
	assign ram_wdata.length = payload_length;

	// read address follows the next lower edge, so the data lines up with
	// le_q in the following cycle; stores never hit the lower edge
	srr_slot_ram u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (seq_num),
		.wdata (ram_wdata),
		.raddr (le_d),
		.rdata (ram_rdata)
	);

	srr_ack_ring u_ack_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.win        (win),
		.lookup_seq (seq_num),
		.hit        (ring_hit),
		.rec        (ack_rec)
	);

	always_comb begin
		state_d      = state_q;
		le_d         = le_q;
		cnt_d        = cnt_q;
		seq_d        = seq_q;
		slot_valid_d = slot_valid_q;
		res_valid_d  = 1'b0;
		res_kind_d   = KIND_ACK;
		res_seq_d    = res_seq_q;
		res_handle_d = '0;
		res_len_d    = '0;
		res_last_d   = 1'b0;
		ack_rec.en   = 1'b0;
		ack_rec.seq  = seq_num;
		ram_we       = 1'b0;
		busy         = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (in_win) begin
						if (checksum_ok) begin
							if (seq_off == '0) begin
								slot_valid_d[seq_num] = 1'b0;
								res_valid_d  = 1'b1;
								res_kind_d   = KIND_DELIVER;
								res_seq_d    = seq_num;
								res_handle_d = payload_handle;
								res_len_d    = payload_length;
								le_d         = le_q + SEQ_W'(1);
								cnt_d        = '0;
								seq_d        = seq_num;
								state_d      = ST_DRAIN;
							end else begin
								// duplicates simply overwrite their slot
								slot_valid_d[seq_num] = 1'b1;
								ram_we      = 1'b1;
								ack_rec.en  = 1'b1;
								res_valid_d = 1'b1;
								res_seq_d   = seq_num;
								res_last_d  = 1'b1;
							end
						end
					end else if (ring_hit) begin
						res_valid_d = 1'b1;
						res_seq_d   = seq_num;
						res_last_d  = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				busy = 1'b1;
				if ((cnt_q < win) && slot_valid_q[le_q]) begin
					slot_valid_d[le_q] = 1'b0;
					res_valid_d  = 1'b1;
					res_kind_d   = KIND_DELIVER;
					res_seq_d    = le_q;
					res_handle_d = ram_rdata.handle;
					res_len_d    = ram_rdata.length;
					le_d         = le_q + SEQ_W'(1);
					cnt_d        = cnt_q + WIN_W'(1);
				end else begin
					ack_rec.en  = 1'b1;
					ack_rec.seq = seq_q;
					res_valid_d = 1'b1;
					res_seq_d   = seq_q;
					res_last_d  = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WINDOW_RESET;
			le_q          <= '0;
			cnt_q         <= '0;
			slot_valid_q  <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			le_q         <= le_d;
			cnt_q        <= cnt_d;
			slot_valid_q <= slot_valid_d;
			res_valid_q  <= res_valid_d;
			if (cfg_wr_en)
				window_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		seq_q        <= seq_d;
		res_kind_q   <= res_kind_d;
		res_seq_q    <= res_seq_d;
		res_handle_q <= res_handle_d;
		res_len_q    <= res_len_d;
		res_last_q   <= res_last_d;
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign out_seq      = res_seq_q;
	assign out_handle   = res_handle_q;
	assign out_length   = res_len_q;
	assign last_of_run  = res_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_of_run == (result_kind == KIND_ACK)))
		else $error("last_of_run does not mark the ack");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (cnt_q <= win))
		else $error("drain ran past the window");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && state_d == ST_IDLE) |=>
		(result_valid && result_kind == KIND_ACK && out_seq == $past(seq_q)))
		else $error("drain did not end with the ack of the in-order packet");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && in_win && checksum_ok && seq_off == '0) |=>
		(state_q == ST_DRAIN && result_valid && result_kind == KIND_DELIVER))
		else $error("in-order packet not delivered first");

endmodule

// ===== src/srr_slot_ram.sv =====
// ----------------------------------------------------------------------------
// srr_slot_ram
// Buffer for out-of-order packet descriptors, one entry per sequence number.
// ----------------------------------------------------------------------------
module srr_slot_ram import srr_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [SEQ_W-1:0] waddr,
	input  slot_t            wdata,
	input  logic [SEQ_W-1:0] raddr,
	output slot_t            rdata
);

	slot_t mem_q [SEQ_SPACE];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/srr_ack_ring.sv =====
// ----------------------------------------------------------------------------
// srr_ack_ring
// Ring of recently acked sequence numbers with a parallel lookup.
// ----------------------------------------------------------------------------
module srr_ack_ring import srr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIN_W-1:0] win,
	input  logic [SEQ_W-1:0] lookup_seq,
	output logic             hit,
	input  ack_rec_t         rec
);

	logic [SEQ_W-1:0]      acked_seq_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] acked_valid_q;
	logic [RING_IDX_W-1:0] wr_idx_q;
	logic [RING_IDX_W-1:0] wr_ptr;
	logic [RING_IDX_W-1:0] wr_idx_d;
	logic [WIN_W-1:0]      nxt_w;

	// index wraps when at or past the window (window may have shrunk)
	always_comb begin
		wr_ptr   = (WIN_W'(wr_idx_q) >= win) ? '0 : wr_idx_q;
		nxt_w    = WIN_W'(wr_ptr) + WIN_W'(1);
		wr_idx_d = (nxt_w >= win) ? '0 : nxt_w[RING_IDX_W-1:0];
	end

	// only the first window entries take part
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (acked_valid_q[i] && (WIN_W'(i) < win) && (acked_seq_q[i] == lookup_seq))
				hit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rec.en)
			acked_seq_q[wr_ptr] <= rec.seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_valid_q <= '0;
			wr_idx_q      <= '0;
		end else if (rec.en) begin
			acked_valid_q[wr_ptr] <= 1'b1;
			wr_idx_q              <= wr_idx_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rec.en |=> acked_valid_q != '0)
		else $error("ack ring record left no valid entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		rec.en |=> (WIN_W'(wr_idx_q) < $past(win)))
		else $error("ack ring write index not wrapped within window");

	assert property (@(posedge clk) disable iff (!arst_n)
		!rec.en |=> $stable(acked_valid_q) && $stable(wr_idx_q))
		else $error("ack ring changed without a record");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective repeat receiver. A scoreboard keeps
// its own copy of the receive window, slot store and ack ring. It predicts
// the deliveries and ACKs of every accepted packet and compares them in order
// with the result strobes. Directed packets come first, then randomized
// sender traffic under several window settings.
// ----------------------------------------------------------------------------
module tb_top import srr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 70;

	typedef struct packed {
		logic                kind;
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
		logic                last;
	} rx_output_t;

	class arq_receiver_model;
		logic [WIN_W-1:0]    window_reg;
		logic [SEQ_W-1:0]    lower_edge;
		bit                  slot_full[SEQ_SPACE];
		logic [HANDLE_W-1:0] slot_handle[SEQ_SPACE];
		logic [LEN_W-1:0]    slot_len[SEQ_SPACE];
		bit                  ring_full[MAX_WINDOW];
		logic [SEQ_W-1:0]    ring_seq[MAX_WINDOW];
		int                  ring_wr;
		rx_output_t          owed[$];
		int                  mismatches;

		function new();
			window_reg = WINDOW_RESET;
			lower_edge = '0;
			ring_wr = 0;
			mismatches = 0;
			for (int i = 0; i < SEQ_SPACE; i++)
				slot_full[i] = 1'b0;
			for (int i = 0; i < MAX_WINDOW; i++)
				ring_full[i] = 1'b0;
		endfunction

		// effective window: zero acts as one, large values clip at the cap
		function int span();
			int w;
			w = window_reg;
			if (w == 0)
				w = 1;
			if (w > WIN_CAP)
				w = WIN_CAP;
			return w;
		endfunction

		function void set_window(logic [WIN_W-1:0] v);
			window_reg = v;
		endfunction

		function void push_output(logic kind, logic [SEQ_W-1:0] seq,
				logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len, logic last);
			rx_output_t o;
			o.kind = kind;
			o.seq = seq;
			o.handle = handle;
			o.length = len;
			o.last = last;
			owed.push_back(o);
		endfunction

		function void note_packet(logic [SEQ_W-1:0] seq, logic ok,
				logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len);
			int w;
			int idx;
			logic [SEQ_W-1:0] seq_off;
			bit hit;
			w = span();
			seq_off = seq - lower_edge;
			if (seq_off < w) begin
				if (!ok)
					return;
				if (seq_off == 0) begin
					slot_full[seq] = 1'b0;
					push_output(KIND_DELIVER, seq, handle, len, 1'b0);
					lower_edge = lower_edge + 1'b1;
					for (int i = 0; i < w && slot_full[lower_edge]; i++) begin
						push_output(KIND_DELIVER, lower_edge, slot_handle[lower_edge],
							slot_len[lower_edge], 1'b0);
						slot_full[lower_edge] = 1'b0;
						lower_edge = lower_edge + 1'b1;
					end
				end else begin
					slot_full[seq] = 1'b1;
					slot_handle[seq] = handle;
					slot_len[seq] = len;
				end
				// ring write index wraps at the effective window
				idx = ring_wr;
				if (idx >= w)
					idx = 0;
				ring_seq[idx] = seq;
				ring_full[idx] = 1'b1;
				idx++;
				if (idx >= w)
					idx = 0;
				ring_wr = idx;
				push_output(KIND_ACK, seq, '0, '0, 1'b1);
			end else begin
				hit = 1'b0;
				for (int i = 0; i < w; i++)
					if (ring_full[i] && ring_seq[i] == seq)
						hit = 1'b1;
				if (hit)
					push_output(KIND_ACK, seq, '0, '0, 1'b1);
			end
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_output(rx_output_t got);
			rx_output_t exp;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0b seq=%0d handle=%h len=%0d",
					got.kind, got.seq, got.handle, got.length));
			end else begin
				exp = owed.pop_front();
				if (got !== exp)
					report_mismatch($sformatf(
						"got kind=%0b seq=%0d handle=%h len=%0d last=%0b, exp %0b %0d %h %0d %0b",
						got.kind, got.seq, got.handle, got.length, got.last,
						exp.kind, exp.seq, exp.handle, exp.length, exp.last));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [SEQ_W-1:0]    seq_num;
	logic                checksum_ok;
	logic [HANDLE_W-1:0] payload_handle;
	logic [LEN_W-1:0]    payload_length;
	logic                cfg_wr_en;
	logic [WIN_W-1:0]    cfg_wr_data;
	logic                result_valid;
	logic                result_kind;
	logic [SEQ_W-1:0]    out_seq;
	logic [HANDLE_W-1:0] out_handle;
	logic [LEN_W-1:0]    out_length;
	logic                last_of_run;

	arq_receiver_model sb = new();
	int cycles = 0;
	bit burst = 1'b0;

	selective_repeat_receiver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.seq_num        (seq_num),
		.checksum_ok    (checksum_ok),
		.payload_handle (payload_handle),
		.payload_length (payload_length),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.result_valid   (result_valid),
		.result_kind    (result_kind),
		.out_seq        (out_seq),
		.out_handle     (out_handle),
		.out_length     (out_length),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// results are checked before the transaction of the same edge is noted;
	// a packet taken at the same edge as a window write still sees the old one
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_output({result_kind, out_seq, out_handle, out_length, last_of_run});
			if (start && !busy)
				sb.note_packet(seq_num, checksum_ok, payload_handle, payload_length);
			if (cfg_wr_en)
				sb.set_window(cfg_wr_data);
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_packet(logic [SEQ_W-1:0] seq, logic ok,
			logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		seq_num = seq;
		checksum_ok = ok;
		payload_handle = handle;
		payload_length = len;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// drop start, wait out every owed result plus the drain latency
	task automatic settle();
		start = 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_window(logic [WIN_W-1:0] v);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic random_traffic(int n);
		int w;
		int r;
		logic [SEQ_W-1:0] seq;
		for (int k = 0; k < n; k++) begin
			if (k % 16 == 0)
				burst = ($urandom_range(0, 3) == 0);
			w = sb.span();
			r = $urandom_range(0, 99);
			// mostly a well-behaved sender: in-window traffic and retransmits
			if (r < 25)
				seq = sb.lower_edge;
			else if (r < 65)
				seq = sb.lower_edge + SEQ_W'((w > 1) ? $urandom_range(1, w - 1) : 0);
			else if (r < 85)
				seq = sb.lower_edge - SEQ_W'($urandom_range(1, w));
			else
				seq = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
			send_packet(seq, $urandom_range(0, 9) != 0, $urandom,
				LEN_W'($urandom_range(0, 255)));
		end
		burst = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		seq_num = '0;
		checksum_ok = 1'b0;
		payload_handle = '0;
		payload_length = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset window of 4, lower edge 0
		send_packet(4'd0, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_packet(4'd0, 1'b1, 32'h1234_5678, 8'd7);  // re-ack below the window
		send_packet(4'd3, 1'b1, 32'h0, 8'd0);
		send_packet(4'd2, 1'b1, 32'hAAAA_5555, 8'd1);
		send_packet(4'd2, 1'b1, 32'h5555_AAAA, 8'd128); // duplicate overwrites slot
		send_packet(4'd2, 1'b0, 32'hDEAD_BEEF, 8'd9);   // corrupt, dropped
		send_packet(4'd9, 1'b1, 32'h0BAD_F00D, 8'd3);   // outside, not acked before
		send_packet(4'd1, 1'b0, 32'h0101_0101, 8'd4);
		send_packet(4'd1, 1'b1, 32'h0202_0202, 8'd5);   // delivers 1 and drains 2, 3
		send_packet(4'd3, 1'b1, 32'h0303_0303, 8'd6);
		send_packet(4'd2, 1'b1, 32'h0404_0404, 8'd8);   // ring holds 2 twice
		settle();

		// fill a wide window, then shrink it so the drain stops short
		write_window(4'd8);
		for (int s = 5; s <= 11; s++)
			send_packet(SEQ_W'(s), 1'b1, $urandom, LEN_W'($urandom_range(0, 255)));
		settle();
		write_window(4'd2);
		send_packet(4'd4, 1'b1, 32'h4444_0000, 8'd44);
		send_packet(4'd7, 1'b1, 32'h7777_0000, 8'd77);  // replaces a stale slot at the edge
		send_packet(4'd10, 1'b1, 32'hAAAA_0000, 8'd10);
		settle();

		write_window(4'd1);
		random_traffic(PHASE_ITEMS);
		settle();
		write_window(4'd8);
		random_traffic(PHASE_ITEMS);
		settle();
		write_window(4'd0);
		random_traffic(PHASE_ITEMS);
		settle();
		write_window(4'd15);
		random_traffic(PHASE_ITEMS);
		settle();
		write_window(4'd3);
		random_traffic(PHASE_ITEMS);
		settle();
		write_window(WIN_W'($urandom_range(0, 15)));
		random_traffic(PHASE_ITEMS);
		settle();

		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
src/srr_pkg.sv
src/srr_slot_ram.sv
src/srr_ack_ring.sv
src/selective_repeat_receiver.sv
test/tb_top.sv
